### src/cpb_pkg.sv
// shared constants and stream field offsets for the contact point builder
`default_nettype none
package cpb_pkg;

	localparam int COORD_BITS_DEF = 21;
	localparam int ID_BITS_DEF = 16;

	// fixed field widths
	localparam int PT_W = 63;
	localparam int MARGIN_W = 20;
	localparam int ID_W = 16;
	localparam int MSUM_W = 21;
	localparam int DEPTH_W = 23;
	localparam int NORM_W = 16;
	localparam int Q_BITS = 15;

	// input tdata layout
	localparam int PA_LO = 0;
	localparam int PB_LO = PA_LO + PT_W;
	localparam int MA_LO = PB_LO + PT_W;
	localparam int MB_LO = MA_LO + MARGIN_W;
	localparam int IDA_LO = MB_LO + MARGIN_W;
	localparam int IDB_LO = IDA_LO + ID_W;
	localparam int V1_LO = IDB_LO + ID_W;
	localparam int V2_LO = V1_LO + PT_W;
	localparam int V3_LO = V2_LO + PT_W;
	localparam int S_TDATA_W = ((V3_LO + PT_W + 7) / 8) * 8;

	// input tuser layout
	localparam int U_OP = 0;
	localparam int U_FRIC = 1;
	localparam int S_TUSER_W = 2;

	// output tdata layout
	localparam int MID_LO = 0;
	localparam int NRM_LO = MID_LO + PT_W;
	localparam int DEP_LO = NRM_LO + 3 * NORM_W;
	localparam int MSUM_LO = DEP_LO + DEPTH_W;
	localparam int MST_LO = MSUM_LO + MSUM_W;
	localparam int SLV_LO = MST_LO + ID_W;
	localparam int M_TDATA_W = ((SLV_LO + ID_W + 7) / 8) * 8;

	// output tuser layout
	localparam int U_OUTSIDE = 0;
	localparam int U_FRIC_OUT = 1;
	localparam int M_TUSER_W = 2;

endpackage
`default_nettype wire

### src/cpb_sqrt_cell.sv
// one result bit of the pipelined integer square root
`default_nettype none
module cpb_sqrt_cell #(
	parameter int RW = 22
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [2*RW-1:0]   op_in,
	input  wire logic [RW+2:0]     rem_in,
	input  wire logic [RW-1:0]     root_in,
	output logic      [2*RW-1:0]   op_out,
	output logic      [RW+2:0]     rem_out,
	output logic      [RW-1:0]     root_out
);

	logic [RW+2:0] rem_w;
	logic [RW+2:0] trial_w;
	logic          ge_w;

	always_comb begin
		// bring down the next two operand bits
		rem_w = {rem_in[RW:0], op_in[2*RW-1:2*RW-2]};
		trial_w = (RW+3)'({root_in, 2'b01});
		ge_w = rem_w >= trial_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_out <= {op_in[2*RW-3:0], 2'b00};
			rem_out <= ge_w ? rem_w - trial_w : rem_w;
			root_out <= {root_in[RW-2:0], ge_w};
		end
	end

endmodule
`default_nettype wire

### src/cpb_div_cell.sv
// one quotient bit of the three normal divisions
`default_nettype none
module cpb_div_cell #(
	parameter int RW = 22,
	parameter int QB = cpb_pkg::Q_BITS,
	parameter bit FIRST = 1'b0
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [RW-1:0]         dist_in,
	input  wire logic [2:0][RW:0]      rem_in,
	input  wire logic [2:0][QB-1:0]    q_in,
	output logic      [RW-1:0]         dist_out,
	output logic      [2:0][RW:0]      rem_out,
	output logic      [2:0][QB-1:0]    q_out
);

	logic [2:0][RW:0]   rem_w;
	logic [2:0][QB-1:0] q_w;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [RW:0] r;
			logic        ge;
			// the leading bit sees the magnitude itself, later bits the doubled remainder
			r = FIRST ? rem_in[l] : {rem_in[l][RW-1:0], 1'b0};
			ge = r >= {1'b0, dist_in};
			rem_w[l] = ge ? r - {1'b0, dist_in} : r;
			q_w[l] = {q_in[l][QB-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_out <= dist_in;
			rem_out <= rem_w;
			q_out <= q_w;
		end
	end

endmodule
`default_nettype wire

### src/contact_point_builder_top.sv
// Contact point builder: one contact record per item, fully pipelined. An item is taken every
// cycle unless a stalled output stops the input; the pipeline is the row of square-root cells
// (one per distance bit) followed by the row of fifteen normal-division cells, with three stages
// before and three after. Each stage holds when the one after it is full and stalled, so a
// stalled output only stops the input once every stage holds an item.
`default_nettype none
module contact_point_builder_top #(
	parameter int ID_BITS = cpb_pkg::ID_BITS_DEF,
	parameter int COORD_BITS = cpb_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// point_a, point_b, margin_a, margin_b, body_a_id, body_b_id, vertex_one, vertex_two,
	// vertex_three, zero fill
	input  wire logic [cpb_pkg::S_TDATA_W-1:0] s_tdata,
	// operation, friction_kind
	input  wire logic [cpb_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// midpoint, unit_normal, depth, margin_sum, master_out, slave_out, zero fill
	output logic      [cpb_pkg::M_TDATA_W-1:0] m_tdata,
	// outside, friction_out
	output logic      [cpb_pkg::M_TUSER_W-1:0] m_tuser
);
	import cpb_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int RW = CW + 1;
	localparam int FW = 2 * DW + 1;
	localparam int PW = FW + NORM_W;
	localparam int SW = PW + 2;
	localparam int CH = RW + Q_BITS;
	localparam int NST = CH + 6;
	localparam int ST_CH = 3;
	localparam int ST_S4 = CH + 3;
	localparam int ST_S5 = CH + 4;
	localparam int ST_S6 = CH + 5;
	localparam int DEPW = DEPTH_W + 1;

	typedef struct packed {
		logic [3*CW-1:0]      mid;
		logic [MSUM_W-1:0]    msum;
		logic [ID_BITS-1:0]   ida;
		logic [ID_BITS-1:0]   idb;
		logic                 fric;
		logic [2:0]           neg;
		logic [2:0][CW-1:0]   dabs;
		logic [2:0][FW-1:0]   face;
	} side_t;

	// valid and ready along the row of stages
	logic [NST-1:0] v_q;
	logic [NST:0]   rdy_w;
	logic [NST-1:0] vin_w;

	always_comb begin
		rdy_w[NST] = m_tready;
		for (int i = NST - 1; i >= 0; i--) begin
			rdy_w[i] = ~v_q[i] | rdy_w[i+1];
		end
		vin_w = {v_q[NST-2:0], s_tvalid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (rdy_w[i]) begin
					v_q[i] <= vin_w[i];
				end
			end
		end
	end

	assign s_tready = rdy_w[0];
	assign m_tvalid = v_q[NST-1];

	// stage 1: differences, midpoint, margins, triangle edges
	logic signed [CW-1:0] a_w [3];
	logic signed [CW-1:0] b_w [3];
	logic signed [CW-1:0] t1_w [3];
	logic signed [CW-1:0] t2_w [3];
	logic signed [CW-1:0] t3_w [3];
	logic signed [DW-1:0] dd_w [3];
	logic signed [DW-1:0] sab_w [3];
	logic signed [DW-1:0] vv_w [3];
	logic signed [DW-1:0] ww_w [3];
	logic [DW-1:0]        abs_w [3];
	side_t                side_w;
	logic                 op_w;

	always_comb begin
		op_w = s_tuser[U_OP];
		side_w = '0;
		side_w.msum = MSUM_W'(s_tdata[MA_LO +: MARGIN_W]) + MSUM_W'(s_tdata[MB_LO +: MARGIN_W]);
		side_w.ida = s_tdata[IDA_LO +: ID_BITS];
		side_w.idb = s_tdata[IDB_LO +: ID_BITS];
		side_w.fric = s_tuser[U_FRIC];
		for (int i = 0; i < 3; i++) begin
			a_w[i] = s_tdata[PA_LO + i*CW +: CW];
			b_w[i] = s_tdata[PB_LO + i*CW +: CW];
			t1_w[i] = s_tdata[V1_LO + i*CW +: CW];
			t2_w[i] = s_tdata[V2_LO + i*CW +: CW];
			t3_w[i] = s_tdata[V3_LO + i*CW +: CW];
			dd_w[i] = DW'(a_w[i]) - DW'(b_w[i]);
			sab_w[i] = DW'(a_w[i]) + DW'(b_w[i]);
			side_w.mid[i*CW +: CW] = sab_w[i][DW-1:1];
			side_w.neg[i] = dd_w[i][DW-1];
			abs_w[i] = dd_w[i][DW-1] ? -dd_w[i] : dd_w[i];
			side_w.dabs[i] = abs_w[i][CW-1:0];
			// a plain contact gets a zero face so the dot product reads outside
			vv_w[i] = op_w ? DW'(t2_w[i]) - DW'(t1_w[i]) : '0;
			ww_w[i] = op_w ? DW'(t3_w[i]) - DW'(t2_w[i]) : '0;
		end
	end

	side_t                side_s1;
	logic signed [DW-1:0] vv_s1 [3];
	logic signed [DW-1:0] ww_s1 [3];

	always_ff @(posedge clk) begin
		if (rdy_w[0]) begin
			side_s1 <= side_w;
			vv_s1 <= vv_w;
			ww_s1 <= ww_w;
		end
	end

	// stage 2: squares and cross product terms
	side_t                  side_s2;
	logic [2*CW-1:0]        sqp_s2 [3];
	logic signed [2*DW-1:0] prod_s2 [6];

	always_ff @(posedge clk) begin
		if (rdy_w[1]) begin
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				sqp_s2[i] <= (2*CW)'(side_s1.dabs[i]) * (2*CW)'(side_s1.dabs[i]);
			end
			prod_s2[0] <= (2*DW)'(vv_s1[1]) * (2*DW)'(ww_s1[2]);
			prod_s2[1] <= (2*DW)'(vv_s1[2]) * (2*DW)'(ww_s1[1]);
			prod_s2[2] <= (2*DW)'(vv_s1[2]) * (2*DW)'(ww_s1[0]);
			prod_s2[3] <= (2*DW)'(vv_s1[0]) * (2*DW)'(ww_s1[2]);
			prod_s2[4] <= (2*DW)'(vv_s1[0]) * (2*DW)'(ww_s1[1]);
			prod_s2[5] <= (2*DW)'(vv_s1[1]) * (2*DW)'(ww_s1[0]);
		end
	end

	// stage 3: squared distance and face normal
	side_t           side_s3;
	side_t           side_f_w;
	logic [2*RW-1:0] sq_s3;

	always_comb begin
		side_f_w = side_s2;
		for (int i = 0; i < 3; i++) begin
			side_f_w.face[i] = FW'(prod_s2[2*i]) - FW'(prod_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_w[2]) begin
			sq_s3 <= (2*RW)'(sqp_s2[0]) + (2*RW)'(sqp_s2[1]) + (2*RW)'(sqp_s2[2]);
			side_s3 <= side_f_w;
		end
	end

	// row of cells: square root, then division
	logic [2*RW-1:0]      sq_op_w   [RW+1];
	logic [RW+2:0]        sq_rem_w  [RW+1];
	logic [RW-1:0]        sq_root_w [RW+1];
	logic [RW-1:0]        dv_dist_w [Q_BITS+1];
	logic [2:0][RW:0]     dv_rem_w  [Q_BITS+1];
	logic [2:0][Q_BITS-1:0] dv_q_w  [Q_BITS+1];
	side_t                side_q    [CH];

	assign sq_op_w[0] = sq_s3;
	assign sq_rem_w[0] = '0;
	assign sq_root_w[0] = '0;

	assign dv_dist_w[0] = sq_root_w[RW];
	assign dv_q_w[0] = '0;
	assign dv_rem_w[0] = {(RW+1)'(side_q[RW-1].dabs[2]), (RW+1)'(side_q[RW-1].dabs[1]),
		(RW+1)'(side_q[RW-1].dabs[0])};

	always_ff @(posedge clk) begin
		for (int k = 0; k < CH; k++) begin
			if (rdy_w[ST_CH+k]) begin
				side_q[k] <= (k == 0) ? side_s3 : side_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		cpb_sqrt_cell #(
			.RW(RW)
		) u_cell (
			.clk     (clk),
			.en      (rdy_w[ST_CH+k]),
			.op_in   (sq_op_w[k]),
			.rem_in  (sq_rem_w[k]),
			.root_in (sq_root_w[k]),
			.op_out  (sq_op_w[k+1]),
			.rem_out (sq_rem_w[k+1]),
			.root_out(sq_root_w[k+1])
		);
	end

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		cpb_div_cell #(
			.RW   (RW),
			.QB   (Q_BITS),
			.FIRST(j == 0)
		) u_cell (
			.clk     (clk),
			.en      (rdy_w[ST_CH+RW+j]),
			.dist_in (dv_dist_w[j]),
			.rem_in  (dv_rem_w[j]),
			.q_in    (dv_q_w[j]),
			.dist_out(dv_dist_w[j+1]),
			.rem_out (dv_rem_w[j+1]),
			.q_out   (dv_q_w[j+1])
		);
	end

	// stage 4: signed normal and depth
	side_t                    side_s4;
	logic [2:0][NORM_W-1:0]   nrm_s4;
	logic [DEPTH_W-1:0]       depth_s4;
	logic [2:0][NORM_W-1:0]   nrm_w;
	logic [DEPW-1:0]          dep_w;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [NORM_W-1:0] qx;
			qx = NORM_W'(dv_q_w[Q_BITS][i]);
			// coincident points give a zero normal
			if (dv_dist_w[Q_BITS] == '0) begin
				nrm_w[i] = '0;
			end else begin
				nrm_w[i] = side_q[CH-1].neg[i] ? -qx : qx;
			end
		end
		dep_w = DEPW'(side_q[CH-1].msum) - DEPW'(dv_dist_w[Q_BITS]);
	end

	always_ff @(posedge clk) begin
		if (rdy_w[ST_S4]) begin
			side_s4 <= side_q[CH-1];
			nrm_s4 <= nrm_w;
			depth_s4 <= dep_w[DEPTH_W-1:0];
		end
	end

	// stage 5: face normal times contact normal
	side_t                  side_s5;
	logic [2:0][NORM_W-1:0] nrm_s5;
	logic [DEPTH_W-1:0]     depth_s5;
	logic signed [PW-1:0]   dp_s5 [3];

	always_ff @(posedge clk) begin
		if (rdy_w[ST_S5]) begin
			side_s5 <= side_s4;
			nrm_s5 <= nrm_s4;
			depth_s5 <= depth_s4;
			for (int i = 0; i < 3; i++) begin
				dp_s5[i] <= PW'($signed(side_s4.face[i])) * PW'($signed(nrm_s4[i]));
			end
		end
	end

	// stage 6: sign of the dot product, output register
	side_t                  side_s6;
	logic [2:0][NORM_W-1:0] nrm_s6;
	logic [DEPTH_W-1:0]     depth_s6;
	logic                   outside_s6;
	logic signed [SW-1:0]   dot_w;

	assign dot_w = SW'(dp_s5[0]) + SW'(dp_s5[1]) + SW'(dp_s5[2]);

	always_ff @(posedge clk) begin
		if (rdy_w[ST_S6]) begin
			side_s6 <= side_s5;
			nrm_s6 <= nrm_s5;
			depth_s6 <= depth_s5;
			outside_s6 <= ~dot_w[SW-1];
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[MID_LO +: 3*CW] = side_s6.mid;
		m_tdata[NRM_LO +: 3*NORM_W] = nrm_s6;
		m_tdata[DEP_LO +: DEPTH_W] = depth_s6;
		m_tdata[MSUM_LO +: MSUM_W] = side_s6.msum;
		m_tdata[MST_LO +: ID_W] = ID_W'(side_s6.ida);
		m_tdata[SLV_LO +: ID_W] = ID_W'(side_s6.idb);
		m_tuser = '0;
		m_tuser[U_OUTSIDE] = outside_s6;
		m_tuser[U_FRIC_OUT] = side_s6.fric;
	end

	// input stalls only when every stage holds an item
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q))
		else $error("input stalled with an empty stage");

	// the first and third normal components never exceed one in magnitude
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(nrm_s6[0]) <= 16'sd16384 && $signed(nrm_s6[0]) >= -16'sd16384
			&& $signed(nrm_s6[2]) <= 16'sd16384 && $signed(nrm_s6[2]) >= -16'sd16384))
		else $error("normal component out of range");

	// distance is never negative so depth stays at or below the margin sum
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(depth_s6) <= $signed({2'b00, side_s6.msum})))
		else $error("depth above margin sum");

endmodule
`default_nettype wire
